FILE: design/aesd_pkg.sv
package aesd_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aesd_in_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } aesd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FIRST,
        ST_ROUND,
        ST_DONE
    } aesd_state_t;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

FILE: design/aesd_key_sched.sv
module aesd_key_sched (
    input  logic         aclk,
    input  logic [127:0] key_cur,
    input  logic [3:0]   round_idx,
    output logic [127:0] key_next
);
    import aesd_pkg::*;

    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;

    always_comb begin
        w0 = key_cur[127:96];
        w1 = key_cur[95:64];
        w2 = key_cur[63:32];
        w3 = key_cur[31:0];
        t = {fwd_sbox(w3[23:16]) ^ rcon(round_idx), fwd_sbox(w3[15:8]),
             fwd_sbox(w3[7:0]), fwd_sbox(w3[31:24])};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        key_next = {n0, n1, n2, n3};
    end

    assert property (@(posedge aclk) (round_idx == 4'd1) |-> (n0[23:0] == (w0[23:0] ^ t[23:0])))
        else $error("key schedule word mismatch");
endmodule

FILE: design/aesd_inv_round.sv
module aesd_inv_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         do_mix,
    output logic [127:0] state_out
);
    import aesd_pkg::*;

    logic [7:0] s [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x1 [4], x2 [4], x3 [4];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127 - 8*i -: 8] ^ round_key[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            a0 = s[4*c];
            a1 = s[4*c+1];
            a2 = s[4*c+2];
            a3 = s[4*c+3];
            x1[0] = xtime(a0); x2[0] = xtime(x1[0]); x3[0] = xtime(x2[0]);
            x1[1] = xtime(a1); x2[1] = xtime(x1[1]); x3[1] = xtime(x2[1]);
            x1[2] = xtime(a2); x2[2] = xtime(x1[2]); x3[2] = xtime(x2[2]);
            x1[3] = xtime(a3); x2[3] = xtime(x1[3]); x3[3] = xtime(x2[3]);
            if (do_mix) begin
                m[4*c]   = (x3[0]^x2[0]^x1[0]) ^ (x3[1]^x1[1]^a1)
                         ^ (x3[2]^x2[2]^a2) ^ (x3[3]^a3);
                m[4*c+1] = (x3[0]^a0) ^ (x3[1]^x2[1]^x1[1])
                         ^ (x3[2]^x1[2]^a2) ^ (x3[3]^x2[3]^a3);
                m[4*c+2] = (x3[0]^x2[0]^a0) ^ (x3[1]^a1)
                         ^ (x3[2]^x2[2]^x1[2]) ^ (x3[3]^x1[3]^a3);
                m[4*c+3] = (x3[0]^x1[0]^a0) ^ (x3[1]^x2[1]^a1)
                         ^ (x3[2]^a2) ^ (x3[3]^x2[3]^x1[3]);
            end else begin
                m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                state_out[127 - 8*(4*c+r) -: 8] = inv_sbox(m[4*((c - r + 4) % 4) + r]);
            end
        end
    end
endmodule

FILE: design/aes128_block_decrypt.sv
// AES-128 ECB decryptor: one 128-bit block enters on s_, its plaintext leaves on m_.
// After reset or a key write the first block first expands round keys 1 to 10,
// one per cycle, into an 11 x 128-bit register file. After a load step a block then
// passes through one shared inverse-round unit, one round key read per cycle,
// and then waits to hand over its result; the block is busy meanwhile.
module aes128_block_decrypt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  aesd_pkg::aesd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aesd_pkg::aesd_out_t m_data
);
    import aesd_pkg::*;

    aesd_state_t state_reg, state_next;
    logic [63:0]  key_high_reg, key_low_reg;
    logic         keys_ready_reg;
    logic [3:0]   cnt_reg, cnt_next;
    logic [127:0] data_reg, ks_reg;
    logic [127:0] rk_mem [11];
    logic [127:0] rk_q, key_next, round_out;

    aesd_key_sched u_ks (.aclk(aclk), .key_cur(ks_reg), .round_idx(cnt_reg),
        .key_next(key_next));
    aesd_inv_round u_rnd (.state_in(data_reg), .round_key(rk_q),
        .do_mix(cnt_reg != 4'd10 && state_reg == ST_ROUND), .state_out(round_out));

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = keys_ready_reg ? ST_FIRST : ST_EXPAND;
                    cnt_next = keys_ready_reg ? 4'd10 : 4'd1;
                end
            end
            ST_EXPAND: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd10) begin
                    state_next = ST_FIRST;
                    cnt_next = 4'd10;
                end
            end
            ST_FIRST: begin
                state_next = ST_ROUND;
                cnt_next = 4'd9;
            end
            ST_ROUND: begin
                if (cnt_reg == 4'd0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_DONE);
        m_data = data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= 4'd0;
            key_high_reg <= '0;
            key_low_reg <= '0;
            keys_ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (cfg_we) begin
                keys_ready_reg <= 1'b0;
                if (cfg_index == CFG_KEY_HIGH) key_high_reg <= cfg_data;
                if (cfg_index == CFG_KEY_LOW) key_low_reg <= cfg_data;
            end else if (state_reg == ST_EXPAND && cnt_reg == 4'd10) begin
                keys_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && !keys_ready_reg) begin
            ks_reg <= {key_high_reg, key_low_reg};
            rk_mem[0] <= {key_high_reg, key_low_reg};
        end else if (state_reg == ST_EXPAND) begin
            ks_reg <= key_next;
            rk_mem[cnt_reg] <= key_next;
        end
        // The last round key is being written as it is first needed.
        if (state_reg == ST_EXPAND && cnt_reg == 4'd10) begin
            rk_q <= key_next;
        end else begin
            rk_q <= rk_mem[cnt_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            data_reg <= s_data;
        end else if (state_reg == ST_FIRST) begin
            data_reg <= round_out;
        end else if (state_reg == ST_ROUND) begin
            data_reg <= (cnt_reg == 4'd0) ? (data_reg ^ rk_q) : round_out;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !m_ready) |=> (state_reg == ST_DONE && $stable(data_reg)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXPAND && cnt_reg == 4'd10 && !cfg_we) |=> keys_ready_reg)
        else $error("keys not marked ready after expansion");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !keys_ready_reg)
        else $error("key write did not clear ready");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIRST) |-> keys_ready_reg || cfg_we || $past(cfg_we))
        else $error("rounds began without keys");
endmodule
